// ===== rtl/core/bspc_pkg.sv =====
// Shared types and constants for the B-spline curve evaluator.
package bspc_pkg;

    localparam int DW = 32;

    localparam logic [1:0] CMD_LOAD_KNOT  = 2'd0;
    localparam logic [1:0] CMD_LOAD_POINT = 2'd1;
    localparam logic [1:0] CMD_EVAL       = 2'd2;
    localparam logic [1:0] CMD_RESERVED   = 2'd3;

    localparam logic [1:0] CFG_ORDER = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;

    localparam logic [2:0] ORDER_RESET = 3'd4;
    localparam logic [4:0] COUNT_RESET = 5'd4;

    // Basis values are held within plus or minus 2^30.
    localparam logic signed [32:0] BASIS_LIM = 33'sd1073741824;
    localparam logic [30:0]        QUOT_LIM  = 31'd1073741824;
    // The accumulator is held within plus or minus 2^62.
    localparam logic signed [63:0] ACC_LIM = 64'sh4000_0000_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRIME_RD,
        S_PRIME_WT,
        S_STEP_RD,
        S_STEP_WT,
        S_TERM_MUL,
        S_TERM_ABS,
        S_TERM_CHK,
        S_TERM_DIV,
        S_TERM_END,
        S_WRITE,
        S_ACC_RD,
        S_ACC_MUL,
        S_ACC_ADD,
        S_DONE
    } bspc_state_t;

endpackage

// ===== rtl/core/bspline_curve_evaluator.sv =====
// Top level of the B-spline curve evaluator: tables, recursion sequencer and divider.
//
// The input channel (s_valid / s_ready) takes one command a beat. A load knot or
// load point beat writes one table entry and gives no result. An evaluate beat
// finds the first knot span holding s_param_t and runs the Cox-de Boor recursion
// level by level over the knot and basis memories, one basis entry per step,
// then sums basis times control point over the affected points. One result beat
// leaves on the m_ channel for each evaluate beat.
// The first level of an evaluate beat also finds the span. Each higher level
// first primes the window, then computes each entry from two terms, either of
// which may need the 31-step shared divider. Then the control points are summed
// and the result is handed over.
// s_ready is low while an evaluation is in progress. A finished result sits in
// the output register; if the receiver stalls, the next loads are still taken
// but the next result waits until the held beat has gone.
// Synchronous reset clears the sequencer and the output valid, and sets the
// order and the point count to 4. The tables keep their contents and must be
// loaded before use. The user must write the configuration port only while idle; the block does not enforce it.
module bspline_curve_evaluator
    import bspc_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int MAX_ORDER  = 4,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [4:0]           cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_command,
    input  logic [4:0]           s_slot,
    input  logic signed [31:0]   s_knot_value,
    input  logic signed [31:0]   s_value_x,
    input  logic signed [31:0]   s_value_y,
    input  logic signed [31:0]   s_value_z,
    input  logic signed [31:0]   s_param_t,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_point_x,
    output logic signed [31:0]   m_point_y,
    output logic signed [31:0]   m_point_z,
    output logic                 m_in_domain
);

    localparam int KD   = MAX_POINTS + MAX_ORDER;
    localparam int KAW  = $clog2(KD);
    localparam int PAW  = $clog2(MAX_POINTS);
    localparam int OW   = $clog2(MAX_ORDER + 1);
    localparam int PCW  = $clog2(MAX_POINTS + 1);
    localparam int CW   = $clog2(KD + 1) + 1;
    localparam logic signed [31:0] ONE_FX   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] ROUND_FX = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    bspc_state_t state_reg, state_next;

    logic [2:0] order_reg;
    logic [4:0] count_reg;

    logic signed [DW-1:0] knot_mem [KD];
    logic signed [DW-1:0] nb_mem   [KD];
    logic signed [DW-1:0] cx_mem   [MAX_POINTS];
    logic signed [DW-1:0] cy_mem   [MAX_POINTS];
    logic signed [DW-1:0] cz_mem   [MAX_POINTS];

    logic signed [DW-1:0] knot_q, nb_q, cx_q, cy_q, cz_q;
    logic [KAW-1:0]       knot_raddr, nb_raddr;
    logic [PAW-1:0]       ctrl_raddr;

    logic signed [DW-1:0] t_reg;
    logic [OW-1:0]        k_reg, m_reg, p_reg;
    logic [PCW-1:0]       pc_reg;
    logic [CW-1:0]        nk_reg;
    logic [KAW-1:0]       j_reg, l_reg, hi_reg;
    logic                 found_reg;
    logic signed [DW-1:0] win_reg [MAX_ORDER+1];
    logic signed [DW-1:0] knew_reg, nb_lo_reg, nb_hi_reg, nbw_reg, term_a_reg;
    logic                 term_sel_reg;
    logic signed [63:0]   prod_reg;
    logic signed [32:0]   den_reg;
    logic [63:0]          rem_reg;
    logic [32:0]          dv_reg;
    logic                 neg_reg;
    logic [30:0]          q_reg;
    logic [4:0]           bit_reg;
    logic signed [63:0]   px_reg, py_reg, pz_reg;
    logic signed [63:0]   ax_reg, ay_reg, az_reg;
    logic                 m_valid_reg;
    logic signed [31:0]   ox_reg, oy_reg, oz_reg;
    logic                 od_reg;

    logic [OW-1:0]        k_eff;
    logic [PCW-1:0]       pc_eff;
    logic                 eval_start, prime_last, level_last, base_hit, zero_term;
    logic                 sat_hit, div_hit, out_load;
    logic signed [32:0]   num_sel, den_sel;
    logic signed [DW-1:0] nval_sel, kmid, term_val;
    logic [30:0]          qmag;
    logic [63:0]          div_shift;
    logic [CW-1:0]        lp1, lo_w, hi_w;

    function automatic logic signed [DW-1:0] clamp_basis(input logic signed [32:0] v);
        if (v > BASIS_LIM) begin
            return DW'(BASIS_LIM);
        end else if (v < -BASIS_LIM) begin
            return DW'(-BASIS_LIM);
        end
        return v[DW-1:0];
    endfunction

    function automatic logic signed [63:0] clamp_acc(input logic signed [63:0] v);
        if (v > ACC_LIM) begin
            return ACC_LIM;
        end else if (v < -ACC_LIM) begin
            return -ACC_LIM;
        end
        return v;
    endfunction

    // Truncating division by 2^FRAC_BITS, then saturation to 32 bits.
    function automatic logic signed [31:0] to_out(input logic signed [63:0] acc);
        logic signed [63:0] r;
        r = (acc + (acc[63] ? ROUND_FX : 64'sd0)) >>> FRAC_BITS;
        if (r > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (r < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return r[31:0];
    endfunction

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_RESET;
            count_reg <= COUNT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_ORDER) begin
                order_reg <= cfg_data[2:0];
            end else if (cfg_index == CFG_COUNT) begin
                count_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        if (order_reg == 3'd0) begin
            k_eff = OW'(1);
        end else if (int'(order_reg) > MAX_ORDER) begin
            k_eff = OW'(MAX_ORDER);
        end else begin
            k_eff = OW'(order_reg);
        end
        if (count_reg < 5'd2) begin
            pc_eff = PCW'(2);
        end else if (int'(count_reg) > MAX_POINTS) begin
            pc_eff = PCW'(MAX_POINTS);
        end else begin
            pc_eff = PCW'(count_reg);
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign eval_start = s_valid && s_ready && (s_command == CMD_EVAL);

    // Memory read addresses.
    always_comb begin
        knot_raddr = KAW'(p_reg);
        nb_raddr   = '0;
        if (state_reg == S_STEP_RD) begin
            knot_raddr = KAW'(CW'(j_reg) + CW'(m_reg));
            nb_raddr   = KAW'(CW'(j_reg) + CW'(1));
        end else if (state_reg == S_ACC_RD) begin
            nb_raddr = j_reg;
        end
        ctrl_raddr = PAW'(j_reg);
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_command == CMD_LOAD_KNOT && int'(s_slot) < KD) begin
            knot_mem[KAW'(s_slot)] <= s_knot_value;
        end
        knot_q <= knot_mem[knot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_WRITE) begin
            nb_mem[j_reg] <= nbw_reg;
        end
        nb_q <= nb_mem[nb_raddr];
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_command == CMD_LOAD_POINT && int'(s_slot) < MAX_POINTS)
        begin
            cx_mem[PAW'(s_slot)] <= s_value_x;
            cy_mem[PAW'(s_slot)] <= s_value_y;
            cz_mem[PAW'(s_slot)] <= s_value_z;
        end
        cx_q <= cx_mem[ctrl_raddr];
        cy_q <= cy_mem[ctrl_raddr];
        cz_q <= cz_mem[ctrl_raddr];
    end

    // Operands of the two recursion terms; the window holds knot[j] upwards.
    always_comb begin
        kmid = win_reg[OW'(m_reg - OW'(1))];
        if (!term_sel_reg) begin
            num_sel  = 33'(t_reg) - 33'(win_reg[0]);
            den_sel  = 33'(kmid) - 33'(win_reg[0]);
            nval_sel = nb_lo_reg;
        end else begin
            num_sel  = 33'(knew_reg) - 33'(t_reg);
            den_sel  = 33'(knew_reg) - 33'(win_reg[1]);
            nval_sel = nb_hi_reg;
        end
        zero_term = (nval_sel == '0) || (den_sel == '0);
        base_hit  = (t_reg >= win_reg[0]) && (t_reg < knot_q);
        sat_hit   = rem_reg >= {dv_reg, 31'd0};
        div_shift = {31'd0, dv_reg} << bit_reg;
        div_hit   = rem_reg >= div_shift;
        qmag      = (q_reg > QUOT_LIM) ? QUOT_LIM : q_reg;
        term_val  = neg_reg ? -DW'({1'b0, qmag}) : DW'({1'b0, qmag});
        prime_last = (p_reg + OW'(1)) == m_reg;
        level_last = (CW'(j_reg) + CW'(m_reg) + CW'(1)) >= nk_reg;
        lp1  = CW'(l_reg) + CW'(1);
        lo_w = (lp1 > CW'(k_reg)) ? lp1 - CW'(k_reg) : '0;
        hi_w = (CW'(l_reg) > CW'(pc_reg) - CW'(1)) ? CW'(pc_reg) - CW'(1) : CW'(l_reg);
        out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (eval_start) state_next = S_PRIME_RD;
            end
            S_PRIME_RD: state_next = S_PRIME_WT;
            S_PRIME_WT: state_next = prime_last ? S_STEP_RD : S_PRIME_RD;
            S_STEP_RD:  state_next = S_STEP_WT;
            S_STEP_WT:  state_next = (m_reg == OW'(1)) ? S_WRITE : S_TERM_MUL;
            S_TERM_MUL: state_next = zero_term ? S_TERM_END : S_TERM_ABS;
            S_TERM_ABS: state_next = S_TERM_CHK;
            S_TERM_CHK: state_next = sat_hit ? S_TERM_END : S_TERM_DIV;
            S_TERM_DIV: begin
                if (bit_reg == 5'd0) state_next = S_TERM_END;
            end
            S_TERM_END: state_next = term_sel_reg ? S_WRITE : S_TERM_MUL;
            S_WRITE: begin
                if (!level_last) begin
                    state_next = S_STEP_RD;
                end else if (!found_reg) begin
                    state_next = S_DONE;
                end else if (m_reg == k_reg) begin
                    state_next = S_ACC_RD;
                end else begin
                    state_next = S_PRIME_RD;
                end
            end
            S_ACC_RD:  state_next = S_ACC_MUL;
            S_ACC_MUL: state_next = S_ACC_ADD;
            S_ACC_ADD: state_next = (j_reg == hi_reg) ? S_DONE : S_ACC_RD;
            S_DONE: begin
                if (!m_valid_reg || m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (eval_start) begin
                    t_reg     <= s_param_t;
                    k_reg     <= k_eff;
                    pc_reg    <= pc_eff;
                    nk_reg    <= CW'(pc_eff) + CW'(k_eff);
                    m_reg     <= OW'(1);
                    p_reg     <= '0;
                    l_reg     <= '0;
                    found_reg <= 1'b0;
                    ax_reg    <= '0;
                    ay_reg    <= '0;
                    az_reg    <= '0;
                end
            end
            S_PRIME_WT: begin
                win_reg[p_reg] <= knot_q;
                nb_lo_reg      <= nb_q;
                p_reg          <= p_reg + OW'(1);
                j_reg          <= '0;
            end
            S_STEP_WT: begin
                knew_reg     <= knot_q;
                nb_hi_reg    <= nb_q;
                term_sel_reg <= 1'b0;
                nbw_reg      <= base_hit ? ONE_FX : '0;
                if (m_reg == OW'(1) && base_hit && !found_reg) begin
                    found_reg <= 1'b1;
                    l_reg     <= j_reg;
                end
            end
            S_TERM_MUL: begin
                prod_reg <= 64'(num_sel * nval_sel);
                den_reg  <= den_sel;
                q_reg    <= '0;
                neg_reg  <= 1'b0;
            end
            S_TERM_ABS: begin
                rem_reg <= prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
                dv_reg  <= den_reg[32] ? 33'(-den_reg) : 33'(den_reg);
                neg_reg <= prod_reg[63] ^ den_reg[32];
            end
            S_TERM_CHK: begin
                bit_reg <= 5'd30;
                if (sat_hit) q_reg <= '1;
            end
            S_TERM_DIV: begin
                if (div_hit) begin
                    rem_reg        <= rem_reg - div_shift;
                    q_reg[bit_reg] <= 1'b1;
                end
                bit_reg <= bit_reg - 5'd1;
            end
            S_TERM_END: begin
                if (!term_sel_reg) begin
                    term_a_reg   <= term_val;
                    term_sel_reg <= 1'b1;
                end else begin
                    nbw_reg <= clamp_basis(33'(term_a_reg) + 33'(term_val));
                end
            end
            S_WRITE: begin
                for (int i = 0; i <= MAX_ORDER; i++) begin
                    if (i + 1 == int'(m_reg)) begin
                        win_reg[i] <= knew_reg;
                    end else if (i < MAX_ORDER) begin
                        win_reg[i] <= win_reg[(i < MAX_ORDER) ? i + 1 : i];
                    end
                end
                nb_lo_reg <= nb_hi_reg;
                if (level_last) begin
                    m_reg  <= m_reg + OW'(1);
                    p_reg  <= '0;
                    j_reg  <= KAW'(lo_w);
                    hi_reg <= KAW'(hi_w);
                end else begin
                    j_reg <= j_reg + KAW'(1);
                end
            end
            S_ACC_MUL: begin
                px_reg <= 64'(nb_q * cx_q);
                py_reg <= 64'(nb_q * cy_q);
                pz_reg <= 64'(nb_q * cz_q);
            end
            S_ACC_ADD: begin
                ax_reg <= clamp_acc(ax_reg + px_reg);
                ay_reg <= clamp_acc(ay_reg + py_reg);
                az_reg <= clamp_acc(az_reg + pz_reg);
                j_reg  <= j_reg + KAW'(1);
            end
            default: begin
            end
        endcase
    end

    // Output register: a held beat is replaced only once it has been taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            ox_reg <= to_out(ax_reg);
            oy_reg <= to_out(ay_reg);
            oz_reg <= to_out(az_reg);
            od_reg <= found_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_point_x   = ox_reg;
    assign m_point_y   = oy_reg;
    assign m_point_z   = oz_reg;
    assign m_in_domain = od_reg;

endmodule

// ===== rtl/core/bspc_checker.sv =====
// Port-level checks for the B-spline curve evaluator, bound to its top level.
module bspc_checker
    import bspc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_command,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_point_x,
    input logic signed [31:0] m_point_y,
    input logic signed [31:0] m_point_z,
    input logic               m_in_domain
);

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_x) && $stable(m_point_y)
            && $stable(m_point_z) && $stable(m_in_domain))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A parameter outside every span gives the origin.
    a_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_domain |-> m_point_x == 0 && m_point_y == 0 && m_point_z == 0)
        else $error("non-zero point outside the domain");

    // An evaluate beat occupies the block for the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_EVAL |=> !s_ready)
        else $error("input ready straight after an evaluate beat");

endmodule

bind bspline_curve_evaluator bspc_checker u_bspc_checker (.*);

// ===== tb/bspline_curve_evaluator_test.sv =====
// Self-checking testbench for the B-spline curve evaluator, with its own curve predictor.
`timescale 1ns / 1ps

module bspline_curve_evaluator_test;
    import bspc_pkg::*;

    localparam int KNOTS = 20;
    localparam int POINTS = 16;
    localparam int ONE = 65536;
    localparam longint BLIM = 64'sd1073741824;
    localparam longint ALIM = 64'sh4000_0000_0000_0000;

    typedef struct {
        int x;
        int y;
        int z;
        bit dom;
    } curve_point_t;

    // Curve predictor with its own copy of the tables and the two registers.
    class curve_scoreboard;
        int order_reg = 4;
        int count_reg = 4;
        longint knots[KNOTS];
        longint px[POINTS];
        longint py[POINTS];
        longint pz[POINTS];
        curve_point_t pending[$];
        int fails = 0;

        function void set_reg(logic [1:0] idx, logic [4:0] d);
            if (idx == CFG_ORDER) order_reg = int'(d[2:0]);
            else if (idx == CFG_COUNT) count_reg = int'(d);
        endfunction

        function int eff_order();
            return (order_reg < 1) ? 1 : (order_reg > 4) ? 4 : order_reg;
        endfunction

        function int eff_knots();
            int pc;
            pc = (count_reg < 2) ? 2 : (count_reg > POINTS) ? POINTS : count_reg;
            return pc + eff_order();
        endfunction

        function longint limit(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function longint term(longint num, longint nval, longint den);
            if (den == 0) return 0;
            return limit((num * nval) / den, BLIM);
        endfunction

        function int to_q16(longint acc);
            longint r;
            r = acc / ONE;
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return int'(r);
        endfunction

        function curve_point_t evaluate(longint t);
            curve_point_t res;
            longint nb[KNOTS];
            longint ax, ay, az, a, b;
            int k, pc, nk, span, lo, hi;
            k = eff_order();
            nk = eff_knots();
            pc = nk - k;
            ax = 0;
            ay = 0;
            az = 0;
            span = -1;
            for (int j = 0; j + 1 < nk; j++) begin
                if (span < 0 && t >= knots[j] && t < knots[j+1]) span = j;
            end
            if (span >= 0) begin
                for (int j = 0; j + 1 < nk; j++)
                    nb[j] = (t >= knots[j] && t < knots[j+1]) ? ONE : 0;
                for (int m = 2; m <= k; m++) begin
                    for (int j = 0; j + m < nk; j++) begin
                        a = term(t - knots[j], nb[j], knots[j+m-1] - knots[j]);
                        b = term(knots[j+m] - t, nb[j+1], knots[j+m] - knots[j+1]);
                        nb[j] = limit(a + b, BLIM);
                    end
                end
                lo = (span - k + 1 < 0) ? 0 : span - k + 1;
                hi = (span > pc - 1) ? pc - 1 : span;
                for (int i = lo; i <= hi; i++) begin
                    ax = limit(ax + nb[i] * px[i], ALIM);
                    ay = limit(ay + nb[i] * py[i], ALIM);
                    az = limit(az + nb[i] * pz[i], ALIM);
                end
            end
            res.x = to_q16(ax);
            res.y = to_q16(ay);
            res.z = to_q16(az);
            res.dom = (span >= 0);
            return res;
        endfunction

        function void note_beat(logic [1:0] c, logic [4:0] sl, int kv, int x, int y, int z,
                                int t);
            if (c == CMD_LOAD_KNOT) begin
                if (sl < KNOTS) knots[sl] = kv;
            end else if (c == CMD_LOAD_POINT) begin
                if (sl < POINTS) begin
                    px[sl] = x;
                    py[sl] = y;
                    pz[sl] = z;
                end
            end else if (c == CMD_EVAL) begin
                pending.insert(pending.size(), evaluate(t));
            end
        endfunction

        function void check_point(int x, int y, int z, bit dom);
            curve_point_t e;
            if (pending.size() == 0) begin
                $display("%0t: result beat with nothing expected: %h %h %h %b",
                         $time, x, y, z, dom);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (e.x !== x) begin
                $display("%0t: point_x expected %h actual %h", $time, e.x, x);
                fails++;
            end
            if (e.y !== y) begin
                $display("%0t: point_y expected %h actual %h", $time, e.y, y);
                fails++;
            end
            if (e.z !== z) begin
                $display("%0t: point_z expected %h actual %h", $time, e.z, z);
                fails++;
            end
            if (e.dom !== dom) begin
                $display("%0t: in_domain expected %b actual %b", $time, e.dom, dom);
                fails++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_command;
    logic [4:0] s_slot;
    logic signed [31:0] s_knot_value, s_value_x, s_value_y, s_value_z, s_param_t;
    logic m_valid;
    logic m_ready;
    logic signed [31:0] m_point_x, m_point_y, m_point_z;
    logic m_in_domain;

    curve_scoreboard sb = new;
    bit quiet = 0;
    int sent = 0;

    bspline_curve_evaluator uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command), .s_slot(s_slot),
        .s_knot_value(s_knot_value), .s_value_x(s_value_x), .s_value_y(s_value_y),
        .s_value_z(s_value_z), .s_param_t(s_param_t),
        .m_valid(m_valid), .m_ready(m_ready), .m_point_x(m_point_x),
        .m_point_y(m_point_y), .m_point_z(m_point_z), .m_in_domain(m_in_domain)
    );

    initial aclk = 0;
    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    initial begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stall bursts, none once the run has gone quiet.
    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready = 0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
            m_ready = 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_point(m_point_x, m_point_y, m_point_z, m_in_domain);
    end

    task automatic send_beat(input logic [1:0] c, input logic [4:0] sl, input int kv,
                             input int x, input int y, input int z, input int t);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid = 0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid = 1;
        s_command = c;
        s_slot = sl;
        s_knot_value = kv;
        s_value_x = x;
        s_value_y = y;
        s_value_z = z;
        s_param_t = t;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(c, sl, kv, x, y, z, t);
        if (c != CMD_RESERVED && !(c == CMD_LOAD_KNOT && sl >= KNOTS)
            && !(c == CMD_LOAD_POINT && sl >= POINTS))
            sent++;
        @(negedge aclk);
        s_valid = 0;
    endtask

    task automatic load_knot(input int sl, input int kv);
        send_beat(CMD_LOAD_KNOT, 5'(sl), kv, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic load_point(input int sl, input int x, input int y, input int z);
        send_beat(CMD_LOAD_POINT, 5'(sl), $urandom, x, y, z, $urandom);
    endtask

    task automatic eval_at(input int t);
        send_beat(CMD_EVAL, 5'($urandom), $urandom, $urandom, $urandom, $urandom, t);
    endtask

    // Waits for every expected result, then lets the block settle before a register write.
    task automatic drain;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [4:0] d);
        @(negedge aclk);
        cfg_wr_en = 1;
        cfg_index = idx;
        cfg_data = d;
        sb.set_reg(idx, d);
        @(negedge aclk);
        cfg_wr_en = 0;
    endtask

    function automatic int coord();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endfunction

    // A sorted knot vector with random spacing, repeated knots now and then.
    task automatic load_sorted_knots;
        int kv;
        kv = int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
        for (int i = 0; i < KNOTS; i++) begin
            load_knot(i, kv);
            case ($urandom_range(0, 6))
                0: kv = kv;
                1, 2: kv = kv + int'($urandom_range(1, ONE));
                default: kv = kv + int'($urandom_range(1, 32'h0010_0000));
            endcase
        end
    endtask

    task automatic random_eval;
        longint lo, hi;
        int nk;
        nk = sb.eff_knots();
        lo = sb.knots[0];
        hi = sb.knots[nk-1];
        case ($urandom_range(0, 9))
            0: eval_at($urandom);
            1, 2: eval_at(int'(sb.knots[$urandom_range(0, nk - 1)]));
            default: begin
                if (hi > lo && hi - lo < 64'd4294967295)
                    eval_at(int'(lo + $urandom_range(0, int'(hi - lo))));
                else
                    eval_at(int'(lo));
            end
        endcase
    endtask

    task automatic run_phase(input int n_items);
        int start;
        start = sent;
        while (sent - start < n_items) begin
            case ($urandom_range(0, 9))
                0: send_beat(2'($urandom), 5'($urandom), $urandom, $urandom, $urandom,
                             $urandom, $urandom);
                1: begin
                    load_sorted_knots;
                    for (int i = 0; i < POINTS; i++) load_point(i, coord(), coord(), coord());
                end
                2, 3: load_point($urandom_range(0, POINTS - 1), coord(), coord(), coord());
                default: random_eval;
            endcase
        end
    endtask

    initial begin
        int orders[10] = '{1, 4, 2, 3, 0, 7, 4, 3, 1, 2};
        int counts[10] = '{2, 16, 7, 10, 1, 31, 4, 16, 16, 2};
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_index = CFG_ORDER;
        cfg_data = 0;
        s_valid = 0;
        s_command = CMD_LOAD_KNOT;
        s_slot = 0;
        s_knot_value = 0;
        s_value_x = 0;
        s_value_y = 0;
        s_value_z = 0;
        s_param_t = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Every table entry is written before the first evaluation.
        for (int i = 0; i < KNOTS; i++) load_knot(i, i * ONE);
        for (int i = 0; i < POINTS; i++) load_point(i, coord(), coord(), coord());

        // Directed part under the reset order and count.
        eval_at(0);
        eval_at(ONE + ONE / 2);
        eval_at(3 * ONE);
        eval_at(7 * ONE);
        eval_at(8 * ONE);
        eval_at(-1);
        eval_at(32'h7FFF_FFFF);
        eval_at(32'h8000_0000);
        send_beat(CMD_RESERVED, 5'd0, 0, 0, 0, 0, ONE);
        load_knot(20, 5);
        load_knot(31, 5);
        load_point(16, 1, 1, 1);
        load_point(31, 1, 1, 1);
        load_point(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        load_point(2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        eval_at(2 * ONE + ONE / 2);
        eval_at(3 * ONE + 7);
        // Repeated knots give zero knot differences in the recursion.
        load_knot(4, 3 * ONE);
        load_knot(5, 3 * ONE);
        eval_at(3 * ONE);
        eval_at(2 * ONE + 123);
        eval_at(5 * ONE + 1);

        for (int p = 0; p < 10; p++) begin
            drain;
            cfg_write(CFG_ORDER, 5'(orders[p]));
            cfg_write(CFG_COUNT, 5'(counts[p]));
            if (p == 9) quiet = 1;
            run_phase(75);
        end

        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.fails == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
